[rtl/assert_macros.svh]
// Assertion macros shared by the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/sacal_pkg.sv]
// Package with sizes, codes and shared types of the age-LRU cache.
package sacal_pkg;
  localparam int NUM_WAYS = 4;
  localparam int LINE_BYTES = 64;
  localparam int WAY_BYTES = 4096;
  localparam int ADDR_BITS = 16;
  localparam int NUM_SETS = WAY_BYTES / LINE_BYTES;
  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int TAG_W = ADDR_BITS - OFF_W - SET_W;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int AGE_W = 16;
  localparam int DATA_ADDR_W = SET_W + OFF_W;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  // One classified word passed from the front end to the back end.
  typedef struct packed {
    mode_t             mode;
    logic [TAG_W-1:0]  tag;
    logic [SET_W-1:0]  set;
    logic [OFF_W-1:0]  offset;
    logic [7:0]        byte_in;
    logic [WAY_W-1:0]  fill_way;
    logic              fill_last;
  } req_t;
endpackage

[rtl/sacal_ram.sv]
// Generic single-port RAM with registered read.
module sacal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/sacal_front.sv]
// Front end: accepts words, splits the address and queues them.
module sacal_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       mode,
  input  logic [15:0]      address,
  input  logic [7:0]       byte_in,
  input  logic [1:0]       fill_way,
  input  logic             fill_last,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             q_valid,
  output sacal_pkg::req_t  q_req,
  input  logic             q_take
);
  sacal_pkg::req_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;
  sacal_pkg::req_t req;

  // Classify the incoming word into tag, set and offset.
  always_comb begin
    req.mode      = sacal_pkg::mode_t'(mode);
    req.offset    = address[sacal_pkg::OFF_W-1:0];
    req.set       = address[sacal_pkg::OFF_W +: sacal_pkg::SET_W];
    req.tag       = address[sacal_pkg::ADDR_BITS-1 -: sacal_pkg::TAG_W];
    req.byte_in   = byte_in;
    req.fill_way  = fill_way;
    req.fill_last = fill_last;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_req    = slot[rd_ptr];
  assign pop      = q_valid && q_take;

  // Two-entry queue between the front and back ends.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/sacal_back.sv]
// Back end: looks up the set, updates ages and data, and forms the result.
module sacal_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sacal_pkg::req_t  q_req,
  output logic             q_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic [7:0]       read_byte,
  output logic [1:0]       victim_way,
  output logic [31:0]      access_total,
  output logic [31:0]      miss_total
);
  localparam int NW = sacal_pkg::NUM_WAYS;
  localparam int NS = sacal_pkg::NUM_SETS;

  sacal_pkg::state_t state;
  sacal_pkg::state_t state_next;
  sacal_pkg::req_t   cur;
  logic [NS-1:0]     valid_bits [NW];
  logic [31:0]       access_count;
  logic [31:0]       miss_count;
  logic [sacal_pkg::SET_W-1:0]  clr_set;

  logic [sacal_pkg::TAG_W-1:0]  tag_rd  [NW];
  logic [sacal_pkg::AGE_W-1:0]  age_rd  [NW];
  logic [7:0]                   data_rd [NW];
  logic [sacal_pkg::TAG_W-1:0]  tag_wd  [NW];
  logic [sacal_pkg::AGE_W-1:0]  age_wd  [NW];
  logic [NW-1:0]                tag_we;
  logic [NW-1:0]                age_we;
  logic [NW-1:0]                data_we;
  logic [sacal_pkg::SET_W-1:0]  ram_set;
  logic [sacal_pkg::OFF_W-1:0]  ram_off;
  logic [7:0]                   data_wd;

  logic [NW-1:0]      way_valid;
  logic [NW-1:0]      match;
  logic               is_access;
  logic               any_hit;
  logic [1:0]         hit_way;
  logic [1:0]         victim;
  logic [7:0]         rd_byte;
  logic               take_now;
  logic               fill_ok;

  // Tag, age and data memories, one of each per way.
  for (genvar w = 0; w < NW; w++) begin : g_way
    sacal_ram #(.WIDTH(sacal_pkg::TAG_W), .DEPTH(NS)) u_tag (
      .clk(clk), .we(tag_we[w]), .addr(ram_set), .wdata(tag_wd[w]), .rdata(tag_rd[w])
    );
    sacal_ram #(.WIDTH(sacal_pkg::AGE_W), .DEPTH(NS)) u_age (
      .clk(clk), .we(age_we[w]), .addr(ram_set), .wdata(age_wd[w]), .rdata(age_rd[w])
    );
    sacal_ram #(.WIDTH(8), .DEPTH(sacal_pkg::LINE_BYTES * NS)) u_data (
      .clk(clk), .we(data_we[w]), .addr({ram_set, ram_off}), .wdata(data_wd),
      .rdata(data_rd[w])
    );
  end

  // The clear pointer addresses the memories after reset, then the queue head
  // when a word is taken and the held word otherwise.
  assign take_now = (state == sacal_pkg::ST_IDLE) && q_valid;
  assign q_take   = take_now;
  assign ram_set  = (state == sacal_pkg::ST_CLEAR) ? clr_set :
                    take_now ? q_req.set : cur.set;
  assign ram_off  = take_now ? q_req.offset : cur.offset;
  assign data_wd  = cur.byte_in;

  // Hit detection and victim choice over the set read in the look state.
  always_comb begin
    is_access = (cur.mode == sacal_pkg::MODE_READ) || (cur.mode == sacal_pkg::MODE_WRITE);
    any_hit   = 1'b0;
    hit_way   = '0;
    rd_byte   = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      way_valid[w] = valid_bits[w][cur.set];
      match[w]     = way_valid[w] && (tag_rd[w] == cur.tag);
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = 2'(w);
        rd_byte = data_rd[w];
      end
    end
  end

  // First invalid way, else the lowest way of greatest age.
  always_comb begin
    logic [sacal_pkg::AGE_W-1:0] best_age;
    logic                        found_inv;
    victim    = '0;
    best_age  = age_rd[0];
    found_inv = 1'b0;
    for (int w = 0; w < NW; w++) begin
      if (!found_inv) begin
        if (!way_valid[w]) begin
          found_inv = 1'b1;
          victim    = 2'(w);
        end else if (w == 0 || age_rd[w] > best_age) begin
          best_age = age_rd[w];
          victim   = 2'(w);
        end
      end
    end
  end

  assign fill_ok = (cur.mode == sacal_pkg::MODE_FILL) && (32'(cur.fill_way) < 32'(NW));

  // Write-back in the look state; only the first matching way counts as hit.
  // The clear state zeroes one age entry of every way per cycle.
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      tag_wd[w]  = cur.tag;
      age_wd[w]  = (any_hit && hit_way == 2'(w)) ? '0 :
                   (age_rd[w] == sacal_pkg::AGE_MAX) ? age_rd[w] : age_rd[w] + 1'b1;
      tag_we[w]  = 1'b0;
      age_we[w]  = 1'b0;
      data_we[w] = 1'b0;
      if (state == sacal_pkg::ST_CLEAR) begin
        age_wd[w] = '0;
        age_we[w] = 1'b1;
      end else if (state == sacal_pkg::ST_LOOK) begin
        age_we[w]  = is_access && any_hit;
        data_we[w] = (cur.mode == sacal_pkg::MODE_WRITE && any_hit && hit_way == 2'(w)) ||
                     (fill_ok && cur.fill_way == 2'(w));
        tag_we[w]  = fill_ok && cur.fill_last && cur.fill_way == 2'(w);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sacal_pkg::ST_CLEAR: begin
        if (clr_set == sacal_pkg::SET_W'(NS - 1)) state_next = sacal_pkg::ST_IDLE;
      end
      sacal_pkg::ST_IDLE: if (q_valid) state_next = sacal_pkg::ST_LOOK;
      sacal_pkg::ST_LOOK: state_next = sacal_pkg::ST_DONE;
      sacal_pkg::ST_DONE: if (!out_stall) state_next = sacal_pkg::ST_IDLE;
      default:            state_next = sacal_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    case (state)
      sacal_pkg::ST_DONE: out_valid = 1'b1;
      default:            out_valid = 1'b0;
    endcase
  end

  assign access_total = access_count;
  assign miss_total   = miss_count;

  // State, held word, valid bits, counters and result registers.
  always_ff @(posedge clk) begin
    if (take_now) begin
      cur <= q_req;
    end
    if (state == sacal_pkg::ST_LOOK) begin
      hit        <= is_access && any_hit;
      read_byte  <= (cur.mode == sacal_pkg::MODE_READ && any_hit) ? rd_byte : 8'd0;
      victim_way <= victim;
    end
    if (rst) begin
      state        <= sacal_pkg::ST_CLEAR;
      clr_set      <= '0;
      access_count <= '0;
      miss_count   <= '0;
      for (int w = 0; w < NW; w++) begin
        valid_bits[w] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == sacal_pkg::ST_CLEAR) begin
        clr_set <= clr_set + 1'b1;
      end
      if (state == sacal_pkg::ST_LOOK) begin
        if (is_access) begin
          access_count <= access_count + 32'd1;
          if (!any_hit) begin
            miss_count <= miss_count + 32'd1;
          end
        end
        if (cur.mode == sacal_pkg::MODE_FLUSH) begin
          for (int w = 0; w < NW; w++) begin
            valid_bits[w] <= '0;
          end
        end else if (fill_ok && cur.fill_last) begin
          valid_bits[cur.fill_way][cur.set] <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/set_assoc_cache_age_lru_core.sv]
// Top level of the set-associative cache with saturating age counters.
//   channel  direction  handshake            fields
//   in       into core  in_valid / in_stall  mode address byte_in fill_way fill_last
//   out      from core  out_valid/out_stall  hit read_byte victim_way access_total miss_total
// Each word passes the back end in order through memory read, look-up with write-back,
// and result hold, over single ported tag, age and data memories.
// A two-entry queue takes words while the back end works or its result is stalled.
// Reset is synchronous and clears valid bits, counters and control; a clearing pass
// over all 64 sets then zeroes every age before the first word is taken from the queue.
`include "assert_macros.svh"
module set_assoc_cache_age_lru_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [7:0]  byte_in,
  input  logic [1:0]  fill_way,
  input  logic        fill_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [7:0]  read_byte,
  output logic [1:0]  victim_way,
  output logic [31:0] access_total,
  output logic [31:0] miss_total
);
  logic            q_valid;
  logic            q_take;
  sacal_pkg::req_t q_req;

  // Front end with the word queue.
  sacal_front u_front (
    .clk(clk), .rst(rst), .mode(mode), .address(address), .byte_in(byte_in),
    .fill_way(fill_way), .fill_last(fill_last), .in_valid(in_valid),
    .in_stall(in_stall), .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  // Back end with memories and counters.
  sacal_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .read_byte(read_byte),
    .victim_way(victim_way), .access_total(access_total), .miss_total(miss_total)
  );

  // A result with no hit never carries a read byte.
  `CHK_IMPL(a_miss_no_byte, out_valid && !hit, read_byte == 8'd0, "read byte on miss")
  // The back end never takes a word while a result is still shown.
  `CHK_IMPL(a_no_take_busy, out_valid, !q_take, "queue popped during result")
  // A stalled result stays shown.
  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(miss_total),
            "stalled result dropped")
endmodule
